// ===== src/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared widths, reset values, register indexes and controller/datapath
// command and status types for the moving-average hysteresis detector.
// ----------------------------------------------------------------------------
package mahd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned HOLD_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Window depth default (valid range 1 to 16 with a 20-bit sum)
  localparam int unsigned WINDOW_DEF = 10;

  // Divider steps: one quotient bit per cycle
  localparam int unsigned STEP_W = $clog2(SUM_W);

  // Reset values and limits
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd52429;
  localparam logic [HOLD_W-1:0]   HOLD_RST      = 4'd3;
  localparam logic [RUN_W-1:0]    RUN_MAX       = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 1'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // take the item: update window and sum, seed divider
    logic step;     // one restoring-division step
    logic finish;   // update hysteresis and write the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // result register can take a new item this cycle
  } dp_stat_t;

endpackage

// ===== src/mahd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mahd_ctrl
// Sequencer: accepts one item, runs the bit-serial divide, then hands the
// result to the output register once it has room.
// ----------------------------------------------------------------------------
module mahd_ctrl
  import mahd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  // An accepted item blocks the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // The result is written only when the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> stat_i.out_free)
    else $error("result written into a busy output register");
`endif

endmodule

// ===== src/mahd_dp.sv =====
// ----------------------------------------------------------------------------
// mahd_dp
// Datapath: window ring, running sum, restoring divider by the fill count,
// hysteresis counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module mahd_dp
  import mahd_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  logic [SAMPLE_W-1:0]   probability_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   average_o,
  output logic                  detected_o,
  output logic                  alarm_o
);

  localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

  logic [SAMPLE_W-1:0] win_q [WINDOW];
  logic [IDX_W-1:0]    wp_q, wp_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [FILL_W-1:0]   rem_q, rem_d;
  logic [FILL_W:0]     trial;
  logic                trial_ge;

  logic [SAMPLE_W-1:0] threshold_q;
  logic [HOLD_W-1:0]   hold_q;
  logic [RUN_W-1:0]    above_q, above_d, below_q, below_d;
  logic [RUN_W-1:0]    above_inc, below_inc;
  logic                flag_q, flag_d, alarm_d, is_above;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] average_q;
  logic                detected_q, alarm_q;

  // Ring pointer, fill count and running sum for the incoming item
  always_comb begin
    wp_d   = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
    fill_d = (fill_q < FILL_MAX) ? fill_q + 1'b1 : fill_q;
    sum_d  = sum_q - SUM_W'(win_q[wp_q]) + SUM_W'(probability_i);
  end

  // One restoring-division step by the fill count
  always_comb begin
    trial    = {rem_q, quo_q[SUM_W-1]};
    trial_ge = (trial >= {1'b0, fill_q});
    rem_d    = trial_ge ? FILL_W'(trial - {1'b0, fill_q}) : trial[FILL_W-1:0];
    quo_d    = {quo_q[SUM_W-2:0], trial_ge};
  end

  // Hysteresis on the finished average
  always_comb begin
    is_above  = (quo_q[SAMPLE_W-1:0] > threshold_q);
    above_inc = (above_q < RUN_MAX) ? above_q + 1'b1 : above_q;
    below_inc = (below_q < RUN_MAX) ? below_q + 1'b1 : below_q;
    flag_d    = flag_q;
    alarm_d   = 1'b0;
    if (is_above) begin
      above_d = above_inc;
      below_d = '0;
      if ((above_inc >= hold_q) && !flag_q) begin
        flag_d  = 1'b1;
        alarm_d = 1'b1;
      end
    end else begin
      below_d = below_inc;
      above_d = '0;
      if ((below_inc >= hold_q) && flag_q) begin
        flag_d = 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // Window, sum, divider and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= '0;
      end
      wp_q    <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      above_q <= '0;
      below_q <= '0;
      flag_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        win_q[wp_q] <= probability_i;
        wp_q        <= wp_d;
        fill_q      <= fill_d;
        sum_q       <= sum_d;
        quo_q       <= sum_d;
        rem_q       <= '0;
      end
      if (cmd_i.step) begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      if (cmd_i.finish) begin
        above_q <= above_d;
        below_q <= below_d;
        flag_q  <= flag_d;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      hold_q      <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_HOLD:      hold_q      <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Result handshake flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      average_q  <= quo_q[SAMPLE_W-1:0];
      detected_q <= flag_d;
      alarm_q    <= alarm_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign detected_o  = detected_q;
  assign alarm_o     = alarm_q;

`ifndef SYNTHESIS
  // The fill count never passes the window depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill count beyond window depth");

  // Partial remainder stays below the divisor while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (fill_q != '0) && (rem_q < fill_q))
    else $error("divider remainder out of range");

  // An alarm goes out only with the detected flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alarm_o) |-> detected_o)
    else $error("alarm without detected flag");
`endif

endmodule

// ===== src/moving_average_hysteresis_detector.sv =====
// ----------------------------------------------------------------------------
// moving_average_hysteresis_detector
// Windowed moving average of classifier probabilities with a debounced
// above-threshold flag and a rising-edge alarm.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_stall_o   probability_i[15:0]
//  out      out_valid_o / out_stall_i average_o[15:0], detected_o, alarm_o
//  cfg      cfg_we_i                  cfg_index_i, cfg_data_i[15:0]
//
//  The accepting edge updates the window and sum, the divider then runs the
//  one-bit-per-cycle divide by the fill count over the 20-bit sum, and a final
//  step updates the hysteresis state and loads the result. The input stalls
//  until then, so a new item is taken only once the last one is through. A
//  stalled result holds in the output register; the block waits in its final
//  step until that register is free. Reset clears the window, sum, runs and
//  flag at once and loads threshold 52429 and hold 3.
// ----------------------------------------------------------------------------
module moving_average_hysteresis_detector
  import mahd_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   probability_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   average_o,
  output logic                  detected_o,
  output logic                  alarm_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  mahd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and state
  mahd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .probability_i (probability_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .average_o     (average_o),
    .detected_o    (detected_o),
    .alarm_o       (alarm_o)
  );

endmodule
